>>> rtl/core/ais_pkg.sv
// Package: shared types and constants of the ARGB image scaler.
`default_nettype none
package ais_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CoordBits = 8;
  localparam int unsigned SizeBits = 9;
  localparam int unsigned ScaleBits = 24;
  localparam int unsigned BankDepth = 1 << (2 * CoordBits - 2);
  localparam int unsigned BankAddrBits = 2 * CoordBits - 2;
  localparam logic [ScaleBits-1:0] ScaleOne = ScaleBits'(1 << FracBits);
  localparam logic [SizeBits-1:0] MaxSize = SizeBits'(1 << CoordBits);

  localparam logic [2:0] RegSrcWidth = 3'd0;
  localparam logic [2:0] RegSrcHeight = 3'd1;
  localparam logic [2:0] RegDstWidth = 3'd2;
  localparam logic [2:0] RegDstHeight = 3'd3;
  localparam logic [2:0] RegInvScale = 3'd4;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqFetch = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [31:0] pixel_in;
  } req_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        status;
  } rsp_t;

  typedef struct packed {
    logic                 valid;
    logic                 err;
    logic [FracBits-1:0]  ax;
    logic [FracBits-1:0]  ay;
    logic                 swap_x;
    logic                 swap_y;
  } samp_t;
endpackage
`default_nettype wire

>>> rtl/core/ais_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module ais_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/ais_addr.sv
// Address stage: sample positions, clamps and bank addresses.
`default_nettype none
module ais_addr import ais_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire req_t                 req,
  input  wire logic [SizeBits-1:0]  src_width,
  input  wire logic [SizeBits-1:0]  src_height,
  input  wire logic [SizeBits-1:0]  dst_width,
  input  wire logic [SizeBits-1:0]  dst_height,
  input  wire logic [ScaleBits-1:0] recip_scale,
  output samp_t                     samp,
  output logic                      wr_en,
  output logic [1:0]                wr_bank,
  output logic [BankAddrBits-1:0]   wr_addr,
  output logic [31:0]               wr_data,
  output logic [BankAddrBits-1:0]   rd_addr [4]
);
  // stage 1: products
  logic                  s1_valid, s1_err, s1_mode_near, s1_mode_copy;
  logic [CoordBits-1:0]  s1_x, s1_y;
  logic [31:0]           s1_px, s1_py;
  logic [CoordBits-1:0]  sw_last, sh_last;
  logic [SizeBits-1:0]   sw, sh;

  always_comb begin
    sw = (src_width == '0) ? SizeBits'(1) : (src_width > MaxSize ? MaxSize : src_width);
    sh = (src_height == '0) ? SizeBits'(1) : (src_height > MaxSize ? MaxSize : src_height);
    sw_last = CoordBits'(sw - SizeBits'(1));
    sh_last = CoordBits'(sh - SizeBits'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      s1_valid <= start && req.req_type == ReqFetch;
      wr_en <= start && req.req_type == ReqLoad &&
               {1'b0, req.pos_x} < sw && {1'b0, req.pos_y} < sh;
    end
    wr_bank <= {req.pos_y[0], req.pos_x[0]};
    wr_addr <= {req.pos_y[CoordBits-1:1], req.pos_x[CoordBits-1:1]};
    wr_data <= req.pixel_in;
    s1_err <= {1'b0, req.pos_x} >= dst_width || {1'b0, req.pos_y} >= dst_height;
    s1_mode_copy <= recip_scale == ScaleOne;
    s1_mode_near <= recip_scale > ScaleOne;
    s1_x <= req.pos_x;
    s1_y <= req.pos_y;
    s1_px <= {24'b0, req.pos_x} * {8'b0, recip_scale};
    s1_py <= {24'b0, req.pos_y} * {8'b0, recip_scale};
  end

  logic [31:0] rx, ry;
  logic [15:0] ix, iy;
  logic [CoordBits-1:0] x0, y0, x1, y1;
  logic [CoordBits-1:0] xa, xb, ya, yb;
  logic [FracBits-1:0] fx, fy;

  always_comb begin
    rx = s1_px + 32'(1 << (FracBits - 1));
    ry = s1_py + 32'(1 << (FracBits - 1));
    if (s1_mode_copy) begin
      ix = 16'(s1_x);
      iy = 16'(s1_y);
    end else if (s1_mode_near) begin
      ix = rx[31:FracBits];
      iy = ry[31:FracBits];
    end else begin
      ix = s1_px[31:FracBits];
      iy = s1_py[31:FracBits];
    end
    x0 = (ix >= 16'(sw)) ? sw_last : CoordBits'(ix);
    y0 = (iy >= 16'(sh)) ? sh_last : CoordBits'(iy);
    x1 = (x0 == sw_last) ? x0 : x0 + CoordBits'(1);
    y1 = (y0 == sh_last) ? y0 : y0 + CoordBits'(1);
    // zero the weights in copy and nearest modes and for a second sample clamped onto the first
    fx = (s1_mode_copy || s1_mode_near || x0 == sw_last) ? '0 : s1_px[FracBits-1:0];
    fy = (s1_mode_copy || s1_mode_near || y0 == sh_last) ? '0 : s1_py[FracBits-1:0];
    // even column/row sample and odd one
    xa = x0[0] ? x1 : x0;
    xb = x0[0] ? x0 : x1;
    ya = y0[0] ? y1 : y0;
    yb = y0[0] ? y0 : y1;
  end

  // banks: 0 even/even, 1 odd x, 2 odd y, 3 odd/odd
  always_comb begin
    rd_addr[0] = {ya[CoordBits-1:1], xa[CoordBits-1:1]};
    rd_addr[1] = {ya[CoordBits-1:1], xb[CoordBits-1:1]};
    rd_addr[2] = {yb[CoordBits-1:1], xa[CoordBits-1:1]};
    rd_addr[3] = {yb[CoordBits-1:1], xb[CoordBits-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samp.valid <= 1'b0;
    end else begin
      samp.valid <= s1_valid;
    end
    samp.err <= s1_err;
    samp.ax <= fx;
    samp.ay <= fy;
    samp.swap_x <= x0[0];
    samp.swap_y <= y0[0];
  end
endmodule
`default_nettype wire

>>> rtl/core/ais_blend.sv
// Blend stage: bilinear weighting of four banked samples per channel.
`default_nettype none
module ais_blend import ais_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire samp_t       samp,
  input  wire logic [31:0] bank_data [4],
  output logic             done,
  output rsp_t             rsp
);
  logic [31:0] p00, p01, p10, p11;
  logic [31:0] q01, q10, q11;
  logic [FracBits:0] wx0, wy0;
  logic [FracBits+8:0] h0 [4];
  logic [FracBits+8:0] h1 [4];

  always_comb begin
    unique case ({samp.swap_y, samp.swap_x})
      2'b00: begin
        p00 = bank_data[0]; p01 = bank_data[1];
        p10 = bank_data[2]; p11 = bank_data[3];
      end
      2'b01: begin
        p00 = bank_data[1]; p01 = bank_data[0];
        p10 = bank_data[3]; p11 = bank_data[2];
      end
      2'b10: begin
        p00 = bank_data[2]; p01 = bank_data[3];
        p10 = bank_data[0]; p11 = bank_data[1];
      end
      default: begin
        p00 = bank_data[3]; p01 = bank_data[2];
        p10 = bank_data[1]; p11 = bank_data[0];
      end
    endcase
    // skip samples that carry no weight
    q01 = (samp.ax == '0) ? p00 : p01;
    q10 = (samp.ay == '0) ? p00 : p10;
    q11 = (samp.ay == '0) ? q01 : ((samp.ax == '0) ? q10 : p11);
    wx0 = (FracBits+1)'(1 << FracBits) - {1'b0, samp.ax};
    wy0 = (FracBits+1)'(1 << FracBits) - {1'b0, samp.ay};
  end

  // stage A: horizontal blend
  logic                  a_valid, a_err;
  logic [FracBits:0]     a_wy0;
  logic [FracBits-1:0]   a_ay;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= samp.valid;
    end
    a_err <= samp.err;
    a_wy0 <= wy0;
    a_ay <= samp.ay;
    for (int c = 0; c < 4; c++) begin
      h0[c] <= (FracBits+9)'(p00[8*c +: 8]) * (FracBits+9)'(wx0)
               + (FracBits+9)'(q01[8*c +: 8]) * (FracBits+9)'(samp.ax);
      h1[c] <= (FracBits+9)'(q10[8*c +: 8]) * (FracBits+9)'(wx0)
               + (FracBits+9)'(q11[8*c +: 8]) * (FracBits+9)'(samp.ax);
    end
  end

  // stage B: vertical blend and round
  logic [2*FracBits+8:0] v [4];
  logic [31:0] pix;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      v[c] = (2*FracBits+9)'(h0[c]) * (2*FracBits+9)'(a_wy0)
             + (2*FracBits+9)'(h1[c]) * (2*FracBits+9)'(a_ay)
             + (2*FracBits+9)'(64'(1) << (2*FracBits - 1));
      pix[8*c +: 8] = v[c][2*FracBits +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
    rsp.status <= a_err;
    rsp.pixel_out <= a_err ? '0 : pix;
  end
endmodule
`default_nettype wire

>>> rtl/core/argb_image_scaler.sv
// Top level: ARGB8888 image scaler with parity-banked frame store.
// Path: done strobes for a fetch after the address stage registers and bank read,
// blend stage A and the output register; loads give no result.
// Throughput: one item per cycle; busy stays low, receiver cannot stall.
// A load write is registered before it lands in a bank; a fetch right behind it sees it.
// Reset sets 256x256 sizes and unit scale; the frame store is undefined until written.
`default_nettype none
module argb_image_scaler import ais_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req,
  output logic             done,
  output rsp_t             rsp,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  logic [SizeBits-1:0]  src_width, src_height, dst_width, dst_height;
  logic [ScaleBits-1:0] recip_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= MaxSize;
      src_height <= MaxSize;
      dst_width <= MaxSize;
      dst_height <= MaxSize;
      recip_scale <= ScaleOne;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSrcWidth:  src_width <= cfg_data[SizeBits-1:0];
        RegSrcHeight: src_height <= cfg_data[SizeBits-1:0];
        RegDstWidth:  dst_width <= cfg_data[SizeBits-1:0];
        RegDstHeight: dst_height <= cfg_data[SizeBits-1:0];
        RegInvScale:  recip_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  samp_t                   samp;
  logic                    wr_en;
  logic [1:0]              wr_bank;
  logic [BankAddrBits-1:0] wr_addr;
  logic [31:0]             wr_data;
  logic [BankAddrBits-1:0] rd_addr [4];
  logic [31:0]             bank_data [4];

  ais_addr u_addr (
    .clk, .rst, .start, .req,
    .src_width, .src_height, .dst_width, .dst_height, .recip_scale,
    .samp, .wr_en, .wr_bank, .wr_addr, .wr_data, .rd_addr
  );

  for (genvar b = 0; b < 4; b++) begin : g_bank
    ais_ram #(.Width(32), .Depth(BankDepth)) u_ram (
      .clk,
      .we(wr_en && wr_bank == 2'(b)),
      .waddr(wr_addr),
      .wdata(wr_data),
      .raddr(rd_addr[b]),
      .rdata(bank_data[b])
    );
  end

  ais_blend u_blend (
    .clk, .rst, .samp, .bank_data, .done, .rsp
  );
endmodule
`default_nettype wire
